// ----- rtl/core/set_assoc_cache_lru_tracker_assert.svh -----
// Assertion macros shared by the cache tracker RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef SET_ASSOC_CACHE_LRU_TRACKER_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SACL_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
		else $error(MSG);

// Next-cycle implication, disabled while reset is asserted (active low).
`define SACL_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
		else $error(MSG);

`endif

// ----- rtl/core/sacl_pkg.sv -----
// Shared types and constants for the set-associative cache LRU tracker.
// No dependencies; imported by every module of the block but sacl_ram.
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

	localparam int unsigned WAY_USED_W    = 2;
	localparam int unsigned CNT_W         = 32;
	localparam int unsigned CFG_IDX_W     = 8;
	localparam int unsigned CFG_DATA_W    = 8;
	localparam int unsigned ADDR_BITS_W   = 6;
	localparam int unsigned SET_BITS_W    = 3;
	localparam int unsigned WAY_BITS_W    = 2;
	localparam int unsigned OFFSET_BITS_W = 5;

	localparam logic [ADDR_BITS_W-1:0]   ADDR_BITS_RST   = 6'd32;
	localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 3'd2;
	localparam logic [WAY_BITS_W-1:0]    WAY_BITS_RST    = 2'd0;
	localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 5'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADDR_BITS   = 8'd0,
		CFG_SET_BITS    = 8'd1,
		CFG_WAY_BITS    = 8'd2,
		CFG_OFFSET_BITS = 8'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_CMP  = 5'b00100,
		S_UPD  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	// Control from the sequencer to the way compare unit.
	typedef struct packed {
		logic step;
		logic first;
	} cmp_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/sacl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the line tags of the tracker.
`timescale 1ns / 1ps
`default_nettype none

module sacl_ram #(
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	localparam int DEPTH = 1 << AW;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sacl_addr_split.sv -----
// Address decode: mask to the configured width, drop the block offset,
// split the rest into set index and tag. Uses sacl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module sacl_addr_split import sacl_pkg::*; #(
	parameter int ADDR_WIDTH = 32,
	parameter int SET_W      = 4
) (
	input  wire logic [ADDR_WIDTH-1:0]    address,
	input  wire logic [ADDR_BITS_W-1:0]   addr_bits,
	input  wire logic [OFFSET_BITS_W-1:0] offset_bits,
	input  wire logic [SET_BITS_W-1:0]    set_bits,
	output logic      [SET_W-1:0]         set_idx,
	output logic      [ADDR_WIDTH-1:0]    tag
);

	logic [ADDR_WIDTH-1:0] addr_mask;
	logic [ADDR_WIDTH-1:0] set_mask;
	logic [ADDR_WIDTH-1:0] above;

	// a shift by the full width or more leaves zero, so the mask saturates
	assign addr_mask = ~({ADDR_WIDTH{1'b1}} << addr_bits);
	assign set_mask  = ~({ADDR_WIDTH{1'b1}} << set_bits);
	assign above     = (address & addr_mask) >> offset_bits;
	assign set_idx   = SET_W'(above & set_mask);
	assign tag       = above >> set_bits;

endmodule

`default_nettype wire

// ----- rtl/core/sacl_way_cmp.sv -----
// Shared way compare unit: one tag match and one age compare per step,
// keeping the hit way or the oldest way seen so far. Uses sacl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sacl_way_cmp import sacl_pkg::*; #(
	parameter int TAG_W = 32,
	parameter int WAY_W = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmp_ctl_t         ctl,
	input  wire logic [WAY_W-1:0] way,
	input  wire logic             line_valid,
	input  wire logic [WAY_W-1:0] age,
	input  wire logic [TAG_W-1:0] line_tag,
	input  wire logic [TAG_W-1:0] key_tag,
	output logic                  match,
	output logic                  hit,
	output logic      [WAY_W-1:0] sel_way
);

	logic             hit_q;
	logic [WAY_W-1:0] sel_q;
	logic [WAY_W-1:0] oldest_q;

	assign match   = line_valid && (line_tag == key_tag);
	assign hit     = hit_q;
	assign sel_way = sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.step) begin
			if (match) begin
				hit_q <= 1'b1;
			end else if (ctl.first) begin
				hit_q <= 1'b0;
			end
		end
	end

	// larger age is older; the first way seeds the search, ties keep the lower way
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (match) begin
				sel_q <= way;
			end else if (ctl.first || (age > oldest_q)) begin
				sel_q    <= way;
				oldest_q <= age;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/set_assoc_cache_lru_tracker.sv -----
// Set-associative cache hit/miss tracker with true LRU replacement.
// Depends on sacl_pkg, sacl_ram, sacl_addr_split, sacl_way_cmp.
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes addr_bits,
//   set_bits, way_bits and offset_bits; cfg_ready is always high. Write only
//   while the block is idle. Unknown indexes are ignored.
//   in channel (in_valid/in_ready, address) takes one address per item.
//   out channel (out_valid/out_ready) returns hit, way_used and the running
//   saturating hit_count and miss_count, one result per item.
// Sequence: the ways of the set are scanned one at a time through the tag RAM
//   and one shared compare unit, each way in a RAM read state and a compare
//   state. The scan stops at a hit or after the last way in use (all ways in
//   use on a miss); an update state and an output state follow. out_valid
//   rises together with in_ready, and a new item is accepted only once the
//   last one has left the output state.
// Stall: the result sits in the output register; the next item is accepted
//   and processed meanwhile, and waits in its last state until the output
//   register is free.
// Reset: configuration returns to addr_bits 32, set_bits 2, way_bits 0,
//   offset_bits 1; all lines invalid, way 0 oldest, totals zero. No clearing
//   pass is needed, the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_cache_lru_tracker_assert.svh"

module set_assoc_cache_lru_tracker import sacl_pkg::*; #(
	parameter int MAX_SET_BITS = 4,
	parameter int MAX_WAY_BITS = 2,
	parameter int ADDR_WIDTH   = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ADDR_WIDTH-1:0] address,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       hit,
	output logic      [WAY_USED_W-1:0] way_used,
	output logic      [CNT_W-1:0]      hit_count,
	output logic      [CNT_W-1:0]      miss_count
);

	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W    = (MAX_WAY_BITS > 0) ? MAX_WAY_BITS : 1;
	localparam int MAX_SETS = 1 << MAX_SET_BITS;
	localparam int MAX_WAYS = 1 << MAX_WAY_BITS;
	localparam int RAM_AW   = (MAX_SET_BITS + MAX_WAY_BITS > 0) ?
		(MAX_SET_BITS + MAX_WAY_BITS) : 1;

	// configuration
	logic [ADDR_BITS_W-1:0]   addr_bits_q;
	logic [SET_BITS_W-1:0]    set_bits_q;
	logic [WAY_BITS_W-1:0]    way_bits_q;
	logic [OFFSET_BITS_W-1:0] offset_bits_q;
	logic [SET_BITS_W-1:0]    sb_eff;
	logic [WAY_BITS_W-1:0]    wb_eff;
	logic [WAY_W-1:0]         last_way;

	// sequencer and item registers
	state_t                state_q;
	logic [SET_W-1:0]      set_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [WAY_W-1:0]      way_q;
	logic [SET_W-1:0]      dec_set;
	logic [ADDR_WIDTH-1:0] dec_tag;

	// per-line state, one row per set
	logic [MAX_WAYS-1:0]             valid_q [MAX_SETS];
	logic [MAX_WAYS-1:0][WAY_W-1:0]  age_q   [MAX_SETS];
	logic [MAX_WAYS-1:0]             valid_row;
	logic [MAX_WAYS-1:0][WAY_W-1:0]  age_row;
	logic [WAY_W-1:0]                sel_age;

	// totals and result
	logic [CNT_W-1:0]      hit_total_q;
	logic [CNT_W-1:0]      miss_total_q;
	logic                  res_hit_q;
	logic [WAY_W-1:0]      res_way_q;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [WAY_USED_W-1:0] way_used_q;
	logic [CNT_W-1:0]      hit_count_q;
	logic [CNT_W-1:0]      miss_count_q;
	logic                  out_free;

	// tag RAM and compare unit
	logic                  ram_we;
	logic                  ram_re;
	logic [RAM_AW-1:0]     ram_waddr;
	logic [RAM_AW-1:0]     ram_raddr;
	logic [ADDR_WIDTH-1:0] ram_rdata;
	cmp_ctl_t              cmp_ctl;
	logic                  cmp_match;
	logic                  cmp_hit;
	logic [WAY_W-1:0]      cmp_sel;

	function automatic logic [RAM_AW-1:0] line_addr(
		input logic [SET_W-1:0] set_idx,
		input logic [WAY_W-1:0] way_idx
	);
		line_addr = (RAM_AW'(set_idx) << MAX_WAY_BITS) | RAM_AW'(way_idx);
	endfunction

	// ---------------------------------------------------------------- config

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_bits_q   <= ADDR_BITS_RST;
			set_bits_q    <= SET_BITS_RST;
			way_bits_q    <= WAY_BITS_RST;
			offset_bits_q <= OFFSET_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ADDR_BITS:   addr_bits_q   <= cfg_data[ADDR_BITS_W-1:0];
				CFG_SET_BITS:    set_bits_q    <= cfg_data[SET_BITS_W-1:0];
				CFG_WAY_BITS:    way_bits_q    <= cfg_data[WAY_BITS_W-1:0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data[OFFSET_BITS_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp set and way counts to what the storage holds
	assign sb_eff = (int'(set_bits_q) > MAX_SET_BITS) ?
		SET_BITS_W'(MAX_SET_BITS) : set_bits_q;
	assign wb_eff = (int'(way_bits_q) > MAX_WAY_BITS) ?
		WAY_BITS_W'(MAX_WAY_BITS) : way_bits_q;
	assign last_way = WAY_W'((32'd1 << wb_eff) - 32'd1);

	// ---------------------------------------------------------------- decode

	sacl_addr_split #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.SET_W      (SET_W)
	) u_addr_split (
		.address     (address),
		.addr_bits   (addr_bits_q),
		.offset_bits (offset_bits_q),
		.set_bits    (sb_eff),
		.set_idx     (dec_set),
		.tag         (dec_tag)
	);

	// ---------------------------------------------------------------- sequencer

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			way_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						way_q   <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cmp_match || (way_q == last_way)) begin
						state_q <= S_UPD;
					end else begin
						way_q   <= way_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_UPD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			set_q <= dec_set;
			tag_q <= dec_tag;
		end
	end

	// ---------------------------------------------------------------- tag scan

	assign ram_re    = (state_q == S_READ);
	assign ram_raddr = line_addr(set_q, way_q);
	assign ram_we    = (state_q == S_UPD) && !cmp_hit;
	assign ram_waddr = line_addr(set_q, cmp_sel);

	sacl_ram #(
		.WIDTH (ADDR_WIDTH),
		.AW    (RAM_AW)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (tag_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign valid_row = valid_q[set_q];
	assign age_row   = age_q[set_q];
	assign sel_age   = age_row[cmp_sel];

	assign cmp_ctl.step  = (state_q == S_CMP);
	assign cmp_ctl.first = (way_q == '0);

	sacl_way_cmp #(
		.TAG_W (ADDR_WIDTH),
		.WAY_W (WAY_W)
	) u_way_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cmp_ctl),
		.way        (way_q),
		.line_valid (valid_row[way_q]),
		.age        (age_row[way_q]),
		.line_tag   (ram_rdata),
		.key_tag    (tag_q),
		.match      (cmp_match),
		.hit        (cmp_hit),
		.sel_way    (cmp_sel)
	);

	// ---------------------------------------------------------------- line state

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SETS; s++) begin
				valid_q[s] <= '0;
				for (int w = 0; w < MAX_WAYS; w++) begin
					age_q[s][w] <= WAY_W'(MAX_WAYS - 1 - w);
				end
			end
			hit_total_q  <= '0;
			miss_total_q <= '0;
		end else if (state_q == S_UPD) begin
			if (cmp_hit) begin
				if (hit_total_q != '1) begin
					hit_total_q <= hit_total_q + 1'b1;
				end
			end else begin
				valid_q[set_q][cmp_sel] <= 1'b1;
				if (miss_total_q != '1) begin
					miss_total_q <= miss_total_q + 1'b1;
				end
			end
			// age every way younger than the accessed one, then make it youngest
			for (int w = 0; w < MAX_WAYS; w++) begin
				if (WAY_W'(w) == cmp_sel) begin
					age_q[set_q][w] <= '0;
				end else if (age_row[w] < sel_age) begin
					age_q[set_q][w] <= age_row[w] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			res_hit_q <= cmp_hit;
			res_way_q <= cmp_sel;
		end
	end

	// ---------------------------------------------------------------- output

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			hit_q        <= res_hit_q;
			way_used_q   <= WAY_USED_W'(res_way_q);
			hit_count_q  <= hit_total_q;
			miss_count_q <= miss_total_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign way_used   = way_used_q;
	assign hit_count  = hit_count_q;
	assign miss_count = miss_count_q;

	// ---------------------------------------------------------------- checks

	`SACL_ASSERT_IMP(a_scan_in_range, clk, arst_n, state_q == S_CMP, way_q <= last_way, "way scan passed the last way in use")
	`SACL_ASSERT_NXT(a_access_youngest, clk, arst_n, state_q == S_UPD, age_q[$past(set_q)][$past(cmp_sel)] == '0, "accessed way not made youngest")
	`SACL_ASSERT_NXT(a_line_valid, clk, arst_n, state_q == S_UPD, valid_q[$past(set_q)][$past(cmp_sel)], "accessed line not valid after update")
	`SACL_ASSERT_NXT(a_hit_keeps_miss, clk, arst_n, (state_q == S_UPD) && cmp_hit, miss_total_q == $past(miss_total_q), "miss total moved on a hit")

endmodule

`default_nettype wire

// ----- sim/set_assoc_cache_lru_tracker_test.sv -----
// Self-checking testbench for set_assoc_cache_lru_tracker: LRU cache lookups, config writes,
// random idling on both channels. Depends on sacl_pkg and the tracker RTL only.
`timescale 1ns / 1ps

module set_assoc_cache_lru_tracker_test import sacl_pkg::*;;

	localparam int MAX_SET_BITS = 4;
	localparam int MAX_WAY_BITS = 2;
	localparam int ADDR_WIDTH   = 32;
	localparam int MAX_SETS     = 1 << MAX_SET_BITS;
	localparam int MAX_WAYS     = 1 << MAX_WAY_BITS;
	localparam int MAX_GAP      = 40;
	localparam int SETTLE       = 16;
	localparam int STALL_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_MAX   = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd4;

	typedef struct packed {
		logic                  hit;
		logic [WAY_USED_W-1:0] way;
		logic [CNT_W-1:0]      hits;
		logic [CNT_W-1:0]      misses;
	} lookup_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [ADDR_WIDTH-1:0] address;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  hit;
	logic [WAY_USED_W-1:0] way_used;
	logic [CNT_W-1:0]      hit_count;
	logic [CNT_W-1:0]      miss_count;

	// cache model state
	logic [5:0]  addr_bits_cfg;
	logic [2:0]  set_bits_cfg;
	logic [1:0]  way_bits_cfg;
	logic [4:0]  offset_bits_cfg;
	logic        line_valid [MAX_SETS][MAX_WAYS];
	logic [31:0] line_tag   [MAX_SETS][MAX_WAYS];
	int unsigned age_rank   [MAX_SETS][MAX_WAYS];
	logic [31:0] hit_total;
	logic [31:0] miss_total;

	lookup_t pending[$];
	int      send_idle_pct;
	int      recv_idle_pct;
	logic    rx_hold;
	int      mismatch_count = 0;
	int      items_sent;
	int      geometries;
	int      cycle_count = 0;

	set_assoc_cache_lru_tracker #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAY_BITS(MAX_WAY_BITS),
		.ADDR_WIDTH  (ADDR_WIDTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.address   (address),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.way_used  (way_used),
		.hit_count (hit_count),
		.miss_count(miss_count)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending.size());
			$display("set_assoc_cache_lru_tracker regression: fail");
			$finish;
		end
	end

	// Look up one address and update LRU state and totals.
	function automatic lookup_t cache_lookup(input logic [31:0] a);
		int unsigned ab, sb, wb, nways, set_idx, way, oldest, rank;
		logic [31:0] masked, above, tag_v;
		logic found;
		lookup_t r;
		ab = (addr_bits_cfg > ADDR_WIDTH) ? ADDR_WIDTH : addr_bits_cfg;
		sb = (set_bits_cfg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_cfg;
		wb = (way_bits_cfg > MAX_WAY_BITS) ? MAX_WAY_BITS : way_bits_cfg;
		nways = 1 << wb;
		masked = (ab >= 32) ? a : (a & ((32'd1 << ab) - 32'd1));
		above = masked >> offset_bits_cfg;
		set_idx = above & ((32'd1 << sb) - 32'd1);
		tag_v = above >> sb;
		found = 1'b0;
		way = 0;
		for (int w = 0; w < nways; w++) begin
			if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag_v) begin
				found = 1'b1;
				way = w;
			end
		end
		if (found) begin
			if (hit_total != '1)
				hit_total++;
		end else begin
			oldest = 0;
			for (int w = 0; w < nways; w++) begin
				if (w == 0 || age_rank[set_idx][w] > oldest) begin
					oldest = age_rank[set_idx][w];
					way = w;
				end
			end
			line_valid[set_idx][way] = 1'b1;
			line_tag[set_idx][way] = tag_v;
			if (miss_total != '1)
				miss_total++;
		end
		// age every way of the set, in use or not
		rank = age_rank[set_idx][way];
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (age_rank[set_idx][w] < rank)
				age_rank[set_idx][w]++;
		end
		age_rank[set_idx][way] = 0;
		r.hit = found;
		r.way = WAY_USED_W'(way);
		r.hits = hit_total;
		r.misses = miss_total;
		return r;
	endfunction

	function automatic void report_lookup(input string what, input lookup_t want,
			input lookup_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			$display("mismatch (%s): expected hit=%0b way=%0d hits=%0d misses=%0d",
				what, want.hit, want.way, want.hits, want.misses);
			$display("  got hit=%0b way=%0d hits=%0d misses=%0d",
				got.hit, got.way, got.hits, got.misses);
		end
	endfunction

	// Check each accepted result, then pick the next out_ready.
	always @(posedge clk) begin : rx
		lookup_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got.hit = hit;
			got.way = way_used;
			got.hits = hit_count;
			got.misses = miss_count;
			if (pending.size() == 0) begin
				report_lookup("no lookup pending", '0, got);
			end else begin
				want = pending.pop_front();
				if (got.hit !== want.hit || got.way !== want.way ||
						got.hits !== want.hits || got.misses !== want.misses)
					report_lookup("lookup result", want, got);
			end
		end
		out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic issue_address(input logic [31:0] a);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		address <= a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending.push_back(cache_lookup(a));
		items_sent++;
	endtask

	// Drop valid and hold until every pending lookup has come back.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_ADDR_BITS:   addr_bits_cfg = d[5:0];
			CFG_SET_BITS:    set_bits_cfg = d[2:0];
			CFG_WAY_BITS:    way_bits_cfg = d[1:0];
			CFG_OFFSET_BITS: offset_bits_cfg = d[4:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input logic [7:0] ab, input logic [7:0] sb,
			input logic [7:0] wb, input logic [7:0] ob);
		wait_for_idle();
		write_reg(CFG_ADDR_BITS, ab);
		write_reg(CFG_SET_BITS, sb);
		write_reg(CFG_WAY_BITS, wb);
		write_reg(CFG_OFFSET_BITS, ob);
		// an unused index must leave every register alone
		write_reg(CFG_SPARE_IDX, 8'($urandom_range(255)));
		cfg_valid <= 1'b0;
		geometries++;
	endtask

	task automatic hold_receiver(input int cycles);
		rx_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	task automatic test_directed_lru();
		// reset geometry: one way, four sets, two-byte blocks
		issue_address(32'h0000_0000);
		issue_address(32'h0000_0000);
		issue_address(32'h0000_0001);
		issue_address(32'hFFFF_FFFF);
		issue_address(32'hFFFF_FFFE);
		issue_address(32'h0000_0008);
		issue_address(32'h0000_0000);
		// oversized fields saturate: 32 address bits, 16 sets, 4 ways
		set_geometry(8'd63, 8'd7, 8'd3, 8'd0);
		issue_address(32'h0000_0010);
		issue_address(32'h0000_0020);
		issue_address(32'h0000_0030);
		issue_address(32'h0000_0040);
		issue_address(32'h0000_0010);
		issue_address(32'h0000_0050);
		issue_address(32'h0000_0010);
		// shrink the way count between accesses to leave one tag in two ways
		set_geometry(8'd8, 8'd0, 8'd0, 8'd0);
		issue_address(32'h0000_00A5);
		set_geometry(8'd8, 8'd0, 8'd1, 8'd0);
		issue_address(32'h0000_005A);
		set_geometry(8'd8, 8'd0, 8'd0, 8'd0);
		issue_address(32'h0000_005A);
		set_geometry(8'd8, 8'd0, 8'd1, 8'd0);
		issue_address(32'h0000_005A);
		// offset covers the whole masked address: tag and set are zero
		set_geometry(8'd8, 8'd2, 8'd1, 8'd28);
		issue_address(32'h0000_00FF);
		issue_address(32'h0000_0000);
		issue_address(32'hFFFF_FFFF);
	endtask

	// One geometry, then a stream drawn mostly from a small pool of blocks.
	task automatic run_traffic(input int kind, input int n);
		logic [31:0] pool[$];
		logic [31:0] a, jitter_mask;
		int pick;
		case (kind)
			0: set_geometry(8'd4, 8'd0, 8'd0, 8'd0);
			1: set_geometry(8'd32, 8'd4, 8'd2, 8'd28);
			2: set_geometry(8'd63, 8'd7, 8'd3, 8'd31);
			3: set_geometry(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255)));
			default: set_geometry(8'($urandom_range(32, 4)), 8'($urandom_range(4)),
				8'($urandom_range(2)), 8'($urandom_range(8)));
		endcase
		repeat ($urandom_range(24, 2)) pool.push_back($urandom);
		jitter_mask = (32'd1 << offset_bits_cfg) - 32'd1;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 75)
				a = pool[$urandom_range(pool.size() - 1)] ^ ($urandom & jitter_mask);
			else if (pick < 88)
				a = pool[$urandom_range(pool.size() - 1)];
			else if (pick < 94)
				a = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			else
				a = $urandom;
			issue_address(a);
		end
	endtask

	task automatic test_random_traffic();
		int phase_send[3] = '{33, 86, 0};
		int phase_recv[3] = '{86, 33, 0};
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = phase_send[p];
			recv_idle_pct = phase_recv[p];
			for (int k = 0; k < 5; k++)
				run_traffic(k, 45);
		end
	endtask

	// Receiver stops for a long stretch while the sender keeps offering.
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_geometry(8'd12, 8'd1, 8'd2, 8'd2);
		fork
			hold_receiver(STALL_CYCLES);
			repeat (40) issue_address($urandom & 32'h0000_0FFF);
		join
	endtask

	// Sender stops until the block has returned everything, then resumes.
	task automatic test_sender_pause();
		send_idle_pct = 20;
		recv_idle_pct = 20;
		repeat (10) issue_address($urandom & 32'h0000_00FF);
		wait_for_idle();
		repeat (10) issue_address($urandom & 32'h0000_00FF);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		address = '0;
		rx_hold = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		items_sent = 0;
		geometries = 0;
		addr_bits_cfg = ADDR_BITS_RST;
		set_bits_cfg = SET_BITS_RST;
		way_bits_cfg = WAY_BITS_RST;
		offset_bits_cfg = OFFSET_BITS_RST;
		for (int s = 0; s < MAX_SETS; s++) begin
			for (int w = 0; w < MAX_WAYS; w++) begin
				line_valid[s][w] = 1'b0;
				line_tag[s][w] = '0;
				age_rank[s][w] = MAX_WAYS - 1 - w;
			end
		end
		hit_total = '0;
		miss_total = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_lru();
		test_random_traffic();
		test_output_stall();
		test_sender_pause();
		wait_for_idle();

		$display("covered %0d lookups (%0d hits, %0d misses) across %0d cache geometries",
			items_sent, hit_total, miss_total, geometries);
		$display("idle mixes 33/86, 86/33, none, a %0d-cycle output stall; %0d mismatches",
			STALL_CYCLES, mismatch_count);
		if (mismatch_count == 0 && pending.size() == 0)
			$display("set_assoc_cache_lru_tracker regression: pass");
		else
			$display("set_assoc_cache_lru_tracker regression: fail");
		$finish;
	end

endmodule
